/* hdl/pkq_pkg.sv */
// shared types, constants and latencies of the particle kinematic quantity block
package pkq_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned KindW = 3;
  localparam int unsigned FracBitsDefault = 16;
  localparam int unsigned LogFrac = 30;
  localparam int unsigned LogW = 5 + LogFrac;
  localparam int unsigned Ln2W = 28;
  localparam logic [Ln2W-1:0] Ln2Q28 = 28'd186065280;

  localparam int unsigned SqrtSteps = 32;
  localparam int unsigned SqrtStepsPerStage = 2;
  localparam int unsigned SqrtStages = SqrtSteps / SqrtStepsPerStage;

  // stages counted from the first input register
  localparam int unsigned LogLat = LogFrac + 1;
  localparam int unsigned RapLat = LogLat + 3;
  localparam int unsigned SqrtLat = 3 + SqrtStages;
  localparam int unsigned PadLat = RapLat - SqrtLat;

  localparam logic [KindW-1:0] KindColumn = 3'd0;
  localparam logic [KindW-1:0] KindPt = 3'd1;
  localparam logic [KindW-1:0] KindP = 3'd2;
  localparam logic [KindW-1:0] KindMass = 3'd3;
  localparam logic [KindW-1:0] KindMt = 3'd4;
  localparam logic [KindW-1:0] KindRapidity = 3'd5;

  typedef struct packed {
    logic signed [DataW-1:0] energy;
    logic signed [DataW-1:0] mom_x;
    logic signed [DataW-1:0] mom_y;
    logic signed [DataW-1:0] mom_z;
    logic signed [DataW-1:0] column_value;
  } pkq_in_t;

  typedef struct packed {
    logic signed [DataW-1:0] quantity_value;
    logic value_valid;
  } pkq_out_t;

endpackage

/* hdl/pkq_delay.sv */
// shift-register delay line with common advance enable
module pkq_delay import pkq_pkg::*; #(
  parameter int unsigned Width = DataW,
  parameter int unsigned Depth = 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [Width-1:0] d_i,
  output logic [Width-1:0] q_o
);

  logic [Width-1:0] tap_q [Depth];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tap_q[0] <= d_i;
      for (int i = 1; i < Depth; i++) begin
        tap_q[i] <= tap_q[i-1];
      end
    end
  end

  assign q_o = tap_q[Depth-1];

endmodule

/* hdl/pkq_radicand.sv */
// squares, sums and radicand selection ahead of the square root
module pkq_radicand import pkq_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [KindW-1:0] kind_i,
  input  logic [DataW-1:0] ax_i,
  input  logic [DataW-1:0] ay_i,
  input  logic [DataW-1:0] az_i,
  input  logic [DataW-1:0] ae_i,
  output logic [63:0]      radicand_o
);

  logic [63:0] sx_q, sy_q, sz_q, se_q;
  logic [63:0] pt2_q, p2_q, ez_q, se2_q;
  logic [63:0] rad_d, rad_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sx_q <= ax_i * ax_i;
      sy_q <= ay_i * ay_i;
      sz_q <= az_i * az_i;
      se_q <= ae_i * ae_i;
      pt2_q <= sx_q + sy_q;
      p2_q <= sx_q + sy_q + sz_q;
      ez_q <= se_q - sz_q;
      se2_q <= se_q;
      rad_q <= rad_d;
    end
  end

  always_comb begin
    unique case (kind_i)
      KindPt: rad_d = pt2_q;
      KindP: rad_d = p2_q;
      KindMass: rad_d = (se2_q > p2_q) ? (se2_q - p2_q) : '0;
      KindMt: rad_d = (se2_q > p2_q) ? ez_q : pt2_q;
      default: rad_d = '0;
    endcase
  end

  assign radicand_o = rad_q;

endmodule

/* hdl/pkq_isqrt.sv */
// pipelined floor integer square root of a 64-bit value
module pkq_isqrt import pkq_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] radicand_i,
  output logic [31:0] root_o
);

  logic [63:0] rem_q [SqrtStages];
  logic [63:0] res_q [SqrtStages];

  for (genvar s = 0; s < SqrtStages; s++) begin : g_stage
    logic [63:0] rem_d, res_d, rem_in, res_in;

    if (s == 0) begin : g_first
      assign rem_in = radicand_i;
      assign res_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign res_in = res_q[s-1];
    end

    always_comb begin
      logic [63:0] bitv;
      rem_d = rem_in;
      res_d = res_in;
      for (int j = 0; j < SqrtStepsPerStage; j++) begin
        bitv = 64'd1 << (62 - 2 * (s * SqrtStepsPerStage + j));
        if (rem_d >= res_d + bitv) begin
          rem_d = rem_d - (res_d + bitv);
          res_d = (res_d >> 1) + bitv;
        end else begin
          res_d = res_d >> 1;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= rem_d;
        res_q[s] <= res_d;
      end
    end
  end

  assign root_o = res_q[SqrtStages-1][31:0];

endmodule

/* hdl/pkq_log2.sv */
// pipelined base-2 logarithm by repeated squaring, one fraction bit a stage
module pkq_log2 import pkq_pkg::*; (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [31:0]     x_i,
  output logic [LogW-1:0] log_o
);

  logic [4:0]         k_q    [LogFrac+1];
  logic [LogFrac:0]   m_q    [LogFrac+1];
  logic [LogFrac-1:0] frac_q [LogFrac+1];

  logic [4:0]  lead;
  logic [31:0] norm;

  always_comb begin
    lead = '0;
    for (int i = 0; i < 32; i++) begin
      if (x_i[i]) lead = 5'(i);
    end
    norm = x_i << (5'd31 - lead);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      k_q[0] <= lead;
      m_q[0] <= norm[31:31-LogFrac];
      frac_q[0] <= '0;
    end
  end

  for (genvar i = 1; i <= LogFrac; i++) begin : g_sq
    logic [2*LogFrac+1:0] sq;
    logic [LogFrac+1:0]   t;
    assign sq = m_q[i-1] * m_q[i-1];
    assign t = sq[2*LogFrac+1:LogFrac];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        k_q[i] <= k_q[i-1];
        if (t[LogFrac+1]) begin
          m_q[i] <= t[LogFrac+1:1];
          frac_q[i] <= frac_q[i-1] | (LogFrac'(1) << (LogFrac - i));
        end else begin
          m_q[i] <= t[LogFrac:0];
          frac_q[i] <= frac_q[i-1];
        end
      end
    end
  end

  assign log_o = {k_q[LogFrac], frac_q[LogFrac]};

endmodule

/* hdl/pkq_rapidity.sv */
// rapidity from the logs of e+pz and e-pz, scaled by ln2/2 and rounded
module pkq_rapidity import pkq_pkg::*; #(
  parameter int unsigned FracBits = FracBitsDefault
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [31:0]             a_i,
  input  logic [31:0]             b_i,
  output logic signed [DataW-1:0] value_o
);

  localparam int unsigned Sh = LogFrac + Ln2W + 1 - FracBits;
  localparam logic [63:0] Rnd = 64'd1 << (Sh - 1);

  logic [LogW-1:0] la, lb;
  logic [LogW:0]   diff;
  logic [35:0]     dm_q;
  logic            neg_q, neg2_q;
  logic [45:0]     plo_q, phi_q;
  logic [63:0]     sum, r;
  logic [31:0]     val_d;
  logic [31:0]     val_q;

  pkq_log2 u_log_a (.clk_i, .en_i, .x_i(a_i), .log_o(la));
  pkq_log2 u_log_b (.clk_i, .en_i, .x_i(b_i), .log_o(lb));

  assign diff = {1'b0, la} - {1'b0, lb};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_q <= diff[LogW];
      dm_q <= 36'(diff[LogW] ? (~diff + 1'b1) : diff);
      neg2_q <= neg_q;
      plo_q <= dm_q[17:0] * Ln2Q28;
      phi_q <= dm_q[35:18] * Ln2Q28;
      val_q <= val_d;
    end
  end

  always_comb begin
    sum = {phi_q, 18'b0} + {18'b0, plo_q} + Rnd;
    r = sum >> Sh;
    if (neg2_q) begin
      val_d = (r > 64'h8000_0000) ? 32'h8000_0000 : (~r[31:0] + 1'b1);
    end else begin
      val_d = (r > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : r[31:0];
    end
  end

  assign value_o = val_q;

endmodule

/* hdl/particle_kinematic_quantity.sv */
// top level of the particle kinematic quantity pipeline
//
//  channel   direction  handshake                     payload
//  in        input      in_valid_i / in_stall_o       in_item_i  (pkq_in_t)
//  out       output     out_valid_o / out_stall_i     out_item_o (pkq_out_t)
//  cfg       input      cfg_valid_i / cfg_ready_o     cfg_data_i (quantity kind)
//
// one item enters per cycle while the output is not stalled; results leave in the order of acceptance
// latency is set by the rapidity path: 30 squaring stages of the log unit
// a stalled output freezes the whole pipeline, nothing is dropped or repeated
// reset clears the valid line and selects column mode
module particle_kinematic_quantity import pkq_pkg::*; #(
  parameter int unsigned FRAC_BITS = FracBitsDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  pkq_in_t          in_item_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output pkq_out_t         out_item_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [KindW-1:0] cfg_data_i
);

  logic             en;
  logic [KindW-1:0] kind_q;
  logic [RapLat:0]  vld_q;
  logic             out_valid_q;
  pkq_out_t         out_item_q, out_item_d;

  logic [DataW-1:0] ax, ay, az, ae;
  logic [DataW-1:0] ax_q, ay_q, az_q, ae_q;
  logic [DataW:0]   a_sum, b_sum;
  logic [31:0]      a_q, b_q;
  logic             undef_q;
  logic [DataW-1:0] col_q;

  logic [63:0]      radicand;
  logic [31:0]      root, root_sat, root_dly;
  logic signed [DataW-1:0] rap;
  logic [DataW:0]   side_dly;

  assign en = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= KindColumn;
    end else if (cfg_valid_i) begin
      kind_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q <= {vld_q[RapLat-1:0], in_valid_i};
      out_valid_q <= vld_q[RapLat];
    end
  end

  always_comb begin
    ax = in_item_i.mom_x[DataW-1] ? (~in_item_i.mom_x + 1'b1) : in_item_i.mom_x;
    ay = in_item_i.mom_y[DataW-1] ? (~in_item_i.mom_y + 1'b1) : in_item_i.mom_y;
    az = in_item_i.mom_z[DataW-1] ? (~in_item_i.mom_z + 1'b1) : in_item_i.mom_z;
    ae = in_item_i.energy[DataW-1] ? (~in_item_i.energy + 1'b1) : in_item_i.energy;
    a_sum = {in_item_i.energy[DataW-1], in_item_i.energy}
          + {in_item_i.mom_z[DataW-1], in_item_i.mom_z};
    b_sum = {in_item_i.energy[DataW-1], in_item_i.energy}
          - {in_item_i.mom_z[DataW-1], in_item_i.mom_z};
  end

  // input stage
  always_ff @(posedge clk_i) begin
    if (en) begin
      ax_q <= ax;
      ay_q <= ay;
      az_q <= az;
      ae_q <= ae;
      a_q <= a_sum[31:0];
      b_q <= b_sum[31:0];
      undef_q <= $signed({in_item_i.energy[DataW-1], in_item_i.energy})
              <= $signed({1'b0, az});
      col_q <= in_item_i.column_value;
    end
  end

  pkq_radicand u_radicand (
    .clk_i, .en_i(en), .kind_i(kind_q),
    .ax_i(ax_q), .ay_i(ay_q), .az_i(az_q), .ae_i(ae_q),
    .radicand_o(radicand)
  );

  pkq_isqrt u_isqrt (.clk_i, .en_i(en), .radicand_i(radicand), .root_o(root));

  assign root_sat = root[31] ? 32'h7FFF_FFFF : root;

  pkq_delay #(.Width(32), .Depth(PadLat)) u_root_dly (
    .clk_i, .en_i(en), .d_i(root_sat), .q_o(root_dly)
  );

  pkq_rapidity #(.FracBits(FRAC_BITS)) u_rapidity (
    .clk_i, .en_i(en), .a_i(a_q), .b_i(b_q), .value_o(rap)
  );

  pkq_delay #(.Width(DataW + 1), .Depth(RapLat)) u_side_dly (
    .clk_i, .en_i(en), .d_i({undef_q, col_q}), .q_o(side_dly)
  );

  always_comb begin
    out_item_d.value_valid = 1'b1;
    unique case (kind_q)
      KindPt, KindP, KindMass, KindMt: out_item_d.quantity_value = root_dly;
      KindRapidity: begin
        out_item_d.quantity_value = side_dly[DataW] ? '0 : rap;
        out_item_d.value_valid = !side_dly[DataW];
      end
      default: out_item_d.quantity_value = side_dly[DataW-1:0];
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o = out_item_q;

endmodule

/* hdl/pkq_checker.sv */
// port-level checks on the particle kinematic quantity top level
module pkq_checker import pkq_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input pkq_in_t          in_item_i,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input pkq_out_t         out_item_o,
  input logic             cfg_valid_i,
  input logic             cfg_ready_o,
  input logic [KindW-1:0] cfg_data_i
);

  // held result survives a stall
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("output item changed while stalled");

  // input stalls only behind a stalled output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

  // undefined rapidity reads as zero
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.value_valid |-> out_item_o.quantity_value == '0)
    else $error("invalid item with non-zero value");

  // nothing leaves during reset
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("output valid during reset");

endmodule

bind particle_kinematic_quantity pkq_checker u_pkq_checker (.*);
